// ===== src/hpcs_pkg.sv =====
// Package for the HV precharge / contactor sequencer.
// Holds widths, status and control codes, register map and shared types.
// No dependencies.
package hpcs_pkg;

  localparam int unsigned SocW   = 7;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  // status codes
  localparam logic [CodeW-1:0] ST_INIT      = 3'd0;
  localparam logic [CodeW-1:0] ST_IDLE      = 3'd1;
  localparam logic [CodeW-1:0] ST_STARTUP   = 3'd2;
  localparam logic [CodeW-1:0] ST_INITPRE   = 3'd3;
  localparam logic [CodeW-1:0] ST_PRECHARGE = 3'd4;
  localparam logic [CodeW-1:0] ST_RUNNING   = 3'd5;
  localparam logic [CodeW-1:0] ST_INTERLOCK = 3'd6;
  localparam logic [CodeW-1:0] ST_LOWCHARGE = 3'd7;

  // control sequencer codes
  localparam logic [CodeW-1:0] CT_STARTUP_CMD = 3'd0;
  localparam logic [CodeW-1:0] CT_NEG_CLOSE   = 3'd1;
  localparam logic [CodeW-1:0] CT_PRE_CLOSE   = 3'd2;
  localparam logic [CodeW-1:0] CT_POS_CLOSE   = 3'd3;
  localparam logic [CodeW-1:0] CT_PRE_OPEN    = 3'd4;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_SOC_LOW    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ILK_HOLD   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_NEG_SETTLE = 3'd2;
  localparam logic [RegIdxW-1:0] REG_PRECHARGE  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_POS_SETTLE = 3'd4;

  // register reset values
  localparam logic [SocW-1:0] SOC_LOW_RST    = 7'd30;
  localparam logic [MsW-1:0]  ILK_HOLD_RST   = 16'd5000;
  localparam logic [MsW-1:0]  NEG_SETTLE_RST = 16'd100;
  localparam logic [MsW-1:0]  PRECHARGE_RST  = 16'd6500;
  localparam logic [MsW-1:0]  POS_SETTLE_RST = 16'd100;

  typedef struct packed {
    logic [SocW-1:0] soc_low_limit;
    logic [MsW-1:0]  interlock_hold_ms;
    logic [MsW-1:0]  neg_settle_ms;
    logic [MsW-1:0]  precharge_ms;
    logic [MsW-1:0]  pos_settle_ms;
  } cfg_t;

  typedef struct packed {
    logic [SocW-1:0]  charge_pct;
    logic             interlock_closed;
    logic             startup_request;
    logic             precharge_sensed;
    logic             pos_sensed;
    logic             neg_sensed;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] monitor_status;
    logic             precharge_drive;
    logic             pos_drive;
    logic             neg_drive;
  } result_t;

  typedef struct packed {
    logic [CodeW-1:0] status;
    logic [CodeW-1:0] control;
    logic [TimeW-1:0] stamp;
  } seq_state_t;

endpackage

// ===== src/hpcs_if.sv =====
// Word channel interfaces for the HV precharge / contactor sequencer.
// Depends on hpcs_pkg.
interface hpcs_in_if import hpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SocW-1:0]  charge_pct;
  logic             interlock_closed;
  logic             startup_request;
  logic             precharge_sensed;
  logic             pos_sensed;
  logic             neg_sensed;
  logic [TimeW-1:0] now_ms;

  modport source (
    output valid, charge_pct, interlock_closed, startup_request,
           precharge_sensed, pos_sensed, neg_sensed, now_ms,
    input  ready
  );
  modport sink (
    input  valid, charge_pct, interlock_closed, startup_request,
           precharge_sensed, pos_sensed, neg_sensed, now_ms,
    output ready
  );
endinterface

interface hpcs_out_if import hpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] monitor_status;
  logic             precharge_drive;
  logic             pos_drive;
  logic             neg_drive;

  modport source (
    output valid, monitor_status, precharge_drive, pos_drive, neg_drive,
    input  ready
  );
  modport sink (
    input  valid, monitor_status, precharge_drive, pos_drive, neg_drive,
    output ready
  );
endinterface

// ===== src/hv_precharge_contactor_sequencer.sv =====
// Top level of the HV battery precharge / contactor sequencer.
// Depends on hpcs_pkg, hpcs_if, hpcs_cfg and hpcs_pipe.
//
// Takes one sensor word per clock while out_o is not stalled and returns one
// status / contactor drive word for each, through the input register and
// then the result register. The status machine, control sequencer and
// shared millisecond stamp all update in the single step between those
// registers, so words may follow each other in every cycle while unstalled;
// the result register lets a new word in while the previous result still
// waits. Thresholds are set over the APB port at byte offsets 0x0 to 0x10
// and should only be written while no word is in flight.
module hv_precharge_contactor_sequencer import hpcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  hpcs_in_if.sink          in_i,
  hpcs_out_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  hpcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hpcs_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// ===== src/hpcs_cfg.sv =====
// APB-style configuration registers of the sequencer.
// Depends on hpcs_pkg.
module hpcs_cfg import hpcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t                cfg_q, cfg_d;
  logic [RegIdxW-1:0]  idx;
  logic                wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SOC_LOW:    cfg_d.soc_low_limit     = pwdata[SocW-1:0];
        REG_ILK_HOLD:   cfg_d.interlock_hold_ms = pwdata[MsW-1:0];
        REG_NEG_SETTLE: cfg_d.neg_settle_ms     = pwdata[MsW-1:0];
        REG_PRECHARGE:  cfg_d.precharge_ms      = pwdata[MsW-1:0];
        REG_POS_SETTLE: cfg_d.pos_settle_ms     = pwdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOC_LOW:    prdata = {{(DataW-SocW){1'b0}}, cfg_q.soc_low_limit};
      REG_ILK_HOLD:   prdata = {{(DataW-MsW){1'b0}}, cfg_q.interlock_hold_ms};
      REG_NEG_SETTLE: prdata = {{(DataW-MsW){1'b0}}, cfg_q.neg_settle_ms};
      REG_PRECHARGE:  prdata = {{(DataW-MsW){1'b0}}, cfg_q.precharge_ms};
      REG_POS_SETTLE: prdata = {{(DataW-MsW){1'b0}}, cfg_q.pos_settle_ms};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.soc_low_limit     <= SOC_LOW_RST;
      cfg_q.interlock_hold_ms <= ILK_HOLD_RST;
      cfg_q.neg_settle_ms     <= NEG_SETTLE_RST;
      cfg_q.precharge_ms      <= PRECHARGE_RST;
      cfg_q.pos_settle_ms     <= POS_SETTLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/hpcs_step.sv =====
// Next-state logic for one word: status machine, control sequencer,
// shared timestamp and contactor drive decode. Depends on hpcs_pkg.
module hpcs_step import hpcs_pkg::*; (
  input  item_t      item_i,
  input  seq_state_t state_i,
  input  cfg_t       cfg_i,
  output seq_state_t state_o,
  output result_t    result_o
);

  logic             low_soc;
  logic             ilk_stamp;
  logic [CodeW-1:0] s_pre;
  logic [CodeW-1:0] s_nxt;
  logic [CodeW-1:0] c_nxt;
  logic [TimeW-1:0] stamp_mid;
  logic [TimeW-1:0] dt;
  logic             pre, pos, neg, ilk;

  assign pre = item_i.precharge_sensed;
  assign pos = item_i.pos_sensed;
  assign neg = item_i.neg_sensed;
  assign ilk = item_i.interlock_closed;

  assign low_soc   = item_i.charge_pct < cfg_i.soc_low_limit;
  assign ilk_stamp = !low_soc && !ilk;
  assign stamp_mid = ilk_stamp ? item_i.now_ms : state_i.stamp;
  // one elapsed time serves both machines; interlock exit needs ilk closed,
  // so it never sees the fresh stamp
  assign dt = item_i.now_ms - stamp_mid;

  always_comb begin
    if (low_soc) begin
      s_pre = ST_LOWCHARGE;
    end else if (!ilk) begin
      s_pre = ST_INTERLOCK;
    end else begin
      s_pre = state_i.status;
    end
    s_nxt = s_pre;
    case (s_pre)
      ST_INIT:      if (item_i.startup_request && !pre && !pos && !neg) s_nxt = ST_IDLE;
      ST_IDLE:      if (!pre && neg && !pos) s_nxt = ST_STARTUP;
      ST_STARTUP:   if (pre && neg && !pos) s_nxt = ST_INITPRE;
      ST_INITPRE:   if (pre && neg && pos) s_nxt = ST_PRECHARGE;
      ST_PRECHARGE: if (!pre && neg && pos) s_nxt = ST_RUNNING;
      ST_RUNNING:   if (pre || !neg || !pos) s_nxt = ST_INIT;
      ST_INTERLOCK: begin
        if (ilk && dt >= {{(TimeW-MsW){1'b0}}, cfg_i.interlock_hold_ms}) s_nxt = ST_INIT;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (s_nxt == ST_INTERLOCK || s_nxt == ST_LOWCHARGE) begin
      c_nxt = CT_STARTUP_CMD;
    end else begin
      c_nxt = state_i.control;
    end
    case (state_i.control)
      CT_STARTUP_CMD: if (s_nxt == ST_IDLE) c_nxt = CT_NEG_CLOSE;
      CT_NEG_CLOSE: begin
        if (dt >= {{(TimeW-MsW){1'b0}}, cfg_i.neg_settle_ms} && s_nxt == ST_STARTUP) begin
          c_nxt = CT_PRE_CLOSE;
        end
      end
      CT_PRE_CLOSE: begin
        if (dt >= {{(TimeW-MsW){1'b0}}, cfg_i.precharge_ms} && s_nxt == ST_INITPRE) begin
          c_nxt = CT_POS_CLOSE;
        end
      end
      CT_POS_CLOSE: begin
        if (dt >= {{(TimeW-MsW){1'b0}}, cfg_i.pos_settle_ms} && s_nxt == ST_PRECHARGE) begin
          c_nxt = CT_PRE_OPEN;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_o.status  = s_nxt;
    state_o.control = c_nxt;
    state_o.stamp   = (ilk_stamp || c_nxt != state_i.control) ? item_i.now_ms
                                                               : state_i.stamp;
  end

  always_comb begin
    result_o.monitor_status  = s_nxt;
    result_o.precharge_drive = 1'b0;
    result_o.pos_drive       = 1'b0;
    result_o.neg_drive       = 1'b0;
    case (c_nxt)
      CT_NEG_CLOSE: result_o.neg_drive = 1'b1;
      CT_PRE_CLOSE: begin
        result_o.precharge_drive = 1'b1;
        result_o.neg_drive       = 1'b1;
      end
      CT_POS_CLOSE: begin
        result_o.precharge_drive = 1'b1;
        result_o.pos_drive       = 1'b1;
        result_o.neg_drive       = 1'b1;
      end
      CT_PRE_OPEN: begin
        result_o.pos_drive = 1'b1;
        result_o.neg_drive = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/hpcs_pipe.sv =====
// Input register, sequencer state and result register around hpcs_step.
// Depends on hpcs_pkg, hpcs_if and hpcs_step.
module hpcs_pipe import hpcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  hpcs_in_if.sink     in_i,
  hpcs_out_if.source  out_o
);

  item_t      item_q;
  logic       in_valid_q, in_valid_d;
  seq_state_t state_q, state_d;
  result_t    res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       advance;
  logic       take;

  hpcs_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign take        = in_i.valid && in_i.ready;
  assign in_valid_d  = take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      state_q.status  <= ST_INIT;
      state_q.control <= CT_STARTUP_CMD;
      state_q.stamp   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.charge_pct       <= in_i.charge_pct;
      item_q.interlock_closed <= in_i.interlock_closed;
      item_q.startup_request  <= in_i.startup_request;
      item_q.precharge_sensed <= in_i.precharge_sensed;
      item_q.pos_sensed       <= in_i.pos_sensed;
      item_q.neg_sensed       <= in_i.neg_sensed;
      item_q.now_ms           <= in_i.now_ms;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.monitor_status  = res_q.monitor_status;
  assign out_o.precharge_drive = res_q.precharge_drive;
  assign out_o.pos_drive       = res_q.pos_drive;
  assign out_o.neg_drive       = res_q.neg_drive;

endmodule
